@@ sv/rvd_pkg.sv @@
package rvd_pkg;

  // configuration port
  localparam int CFG_W  = 17;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_CENTER_X     = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y     = 2'd1;
  localparam logic [IDX_W-1:0] REG_STRENGTH     = 2'd2;
  localparam logic [IDX_W-1:0] REG_FALLOFF_SIZE = 2'd3;

  // register and datapath widths
  localparam int CEN_W  = 17;
  localparam int AMT_W  = 9;
  localparam int SIZE_W = 12;
  localparam int REF_W  = 17;
  localparam int DEN_W  = REF_W + SIZE_W;
  localparam int FACT_W = 9;
  localparam int QUO_W  = 8;
  localparam int GAIN_W = 17;
  localparam int FRAC_W = 16;

  localparam logic signed [CEN_W-1:0] CENTER_RST   = '0;
  localparam logic [AMT_W-1:0]        STRENGTH_RST = 9'd128;
  localparam logic [SIZE_W-1:0]       SIZE_RST     = 12'd128;
  localparam logic [SIZE_W-1:0]       SIZE_MIN     = 12'd3;
  localparam logic [AMT_W-1:0]        AMT_MAX      = 9'd256;
  localparam logic [FACT_W-1:0]       FACTOR_ONE   = 9'd256;
  localparam logic [GAIN_W-1:0]       GAIN_ONE     = 17'h10000;
  localparam logic [FRAC_W-1:0]       ROUND_HALF   = 16'h8000;

  typedef struct packed {
    logic signed [CEN_W-1:0] cx;
    logic signed [CEN_W-1:0] cy;
    logic [AMT_W-1:0]        amount;
    logic [DEN_W-1:0]        den;
    logic                    den_zero;
  } rvd_cfg_t;

endpackage

@@ sv/rvd_cfg.sv @@
module rvd_cfg import rvd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output rvd_cfg_t         cset,
  output logic             busy
);

  localparam int RAD_W = 2 * REF_W;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(REF_W - 1);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ABS  = 3'd1;
  localparam logic [2:0] PH_SQR  = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_ROOT = 3'd4;
  localparam logic [2:0] PH_MUL  = 3'd5;

  logic signed [CEN_W-1:0] cx_r, cy_r;
  logic [AMT_W-1:0]        strength_r;
  logic [SIZE_W-1:0]       size_r;
  logic [2:0]              phase_r, phase_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [REF_W-1:0]        ax_r, ay_r;
  logic [RAD_W-1:0]        sqx_r, sqy_r, rad_r;
  logic [REF_W-1:0]        root_r;
  logic [REF_W:0]          rem_r;
  logic [DEN_W-1:0]        den_r;
  logic                    den_zero_r;
  logic [SIZE_W-1:0]       size_c;
  logic [REF_W+2:0]        remc;
  logic [REF_W+2:0]        trial;
  logic                    ge;

  assign cfg_ready = 1'b1;
  assign busy      = (phase_r != PH_IDLE);
  assign size_c    = (size_r < SIZE_MIN) ? SIZE_MIN : size_r;

  assign cset.cx       = cx_r;
  assign cset.cy       = cy_r;
  assign cset.amount   = (strength_r > AMT_MAX) ? AMT_MAX : strength_r;
  assign cset.den      = den_r;
  assign cset.den_zero = den_zero_r;

  // one root digit per cycle
  assign remc  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (remc >= trial);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      PH_IDLE: phase_nxt = PH_IDLE;
      PH_ABS:  phase_nxt = PH_SQR;
      PH_SQR:  phase_nxt = PH_SUM;
      PH_SUM: begin
        phase_nxt = PH_ROOT;
        cnt_nxt   = '0;
      end
      PH_ROOT: begin
        if (cnt_r == ROOT_LAST) begin
          phase_nxt = PH_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      PH_MUL:  phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
    // any register write restarts the reference computation
    if (cfg_valid) begin
      phase_nxt = PH_ABS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r       <= CENTER_RST;
      cy_r       <= CENTER_RST;
      strength_r <= STRENGTH_RST;
      size_r     <= SIZE_RST;
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      den_r      <= '0;
      den_zero_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CENTER_X:     cx_r       <= $signed(cfg_data[CEN_W-1:0]);
          REG_CENTER_Y:     cy_r       <= $signed(cfg_data[CEN_W-1:0]);
          REG_STRENGTH:     strength_r <= cfg_data[AMT_W-1:0];
          REG_FALLOFF_SIZE: size_r     <= cfg_data[SIZE_W-1:0];
        endcase
      end
      if (phase_r == PH_MUL) begin
        den_r      <= DEN_W'(root_r) * DEN_W'(size_c);
        den_zero_r <= (root_r == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == PH_ABS) begin
      ax_r <= cx_r[CEN_W-1] ? REF_W'(-cx_r) : REF_W'(cx_r);
      ay_r <= cy_r[CEN_W-1] ? REF_W'(-cy_r) : REF_W'(cy_r);
    end
    if (phase_r == PH_SQR) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
    if (phase_r == PH_SUM) begin
      rad_r  <= sqx_r + sqy_r;
      root_r <= '0;
      rem_r  <= '0;
    end
    if (phase_r == PH_ROOT) begin
      rad_r  <= rad_r << 2;
      root_r <= {root_r[REF_W-2:0], ge};
      rem_r  <= ge ? (REF_W+1)'(remc - trial) : remc[REF_W:0];
    end
  end

endmodule

@@ sv/rvd_sqrt_pipe.sv @@
module rvd_sqrt_pipe import rvd_pkg::*; #(
  parameter int DW = 18,
  parameter int TW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  output logic            in_rdy,
  input  logic [2*DW-1:0] in_rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_v,
  input  logic            out_rdy,
  output logic [DW-1:0]   out_root,
  output logic [TW-1:0]   out_tag
);

  localparam int RW = 2 * DW;

  logic [DW-1:0] v_r;
  logic [DW:0]   rdy;
  logic [DW-1:0] root_r  [DW];
  logic [DW:0]   rem_r   [DW];
  logic [RW-1:0] rad_r   [DW];
  logic [TW-1:0] tag_r   [DW];
  logic [DW-1:0] root_p  [DW];
  logic [DW:0]   rem_p   [DW];
  logic [RW-1:0] rad_p   [DW];
  logic [TW-1:0] tag_p   [DW];
  logic [DW-1:0] root_nxt[DW];
  logic [DW:0]   rem_nxt [DW];
  logic [DW+2:0] remc    [DW];
  logic [DW+2:0] trial   [DW];
  logic [DW-1:0] v_in;

  // a stage takes a word when it is empty or its word moves on
  always_comb begin
    rdy[DW] = out_rdy;
    for (int i = DW - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    root_p[0] = '0;
    rem_p[0]  = '0;
    rad_p[0]  = in_rad;
    tag_p[0]  = in_tag;
    for (int i = 1; i < DW; i++) begin
      root_p[i] = root_r[i-1];
      rem_p[i]  = rem_r[i-1];
      rad_p[i]  = rad_r[i-1];
      tag_p[i]  = tag_r[i-1];
    end
    for (int i = 0; i < DW; i++) begin
      remc[i]  = {rem_p[i], rad_p[i][RW-1 -: 2]};
      trial[i] = {1'b0, root_p[i], 2'b01};
      if (remc[i] >= trial[i]) begin
        rem_nxt[i]  = (DW+1)'(remc[i] - trial[i]);
        root_nxt[i] = {root_p[i][DW-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = remc[i][DW:0];
        root_nxt[i] = {root_p[i][DW-2:0], 1'b0};
      end
    end
  end

  assign v_in = {v_r[DW-2:0], in_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < DW; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DW; i++) begin
      if (rdy[i]) begin
        root_r[i] <= root_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        rad_r[i]  <= rad_p[i] << 2;
        tag_r[i]  <= tag_p[i];
      end
    end
  end

  assign in_rdy   = rdy[0];
  assign out_v    = v_r[DW-1];
  assign out_root = root_r[DW-1];
  assign out_tag  = tag_r[DW-1];

endmodule

@@ sv/rvd_div_pipe.sv @@
module rvd_div_pipe import rvd_pkg::*; #(
  parameter int DW = 18,
  parameter int TW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  output logic              in_rdy,
  input  logic [DW-1:0]     in_dist,
  input  logic [TW-1:0]     in_tag,
  input  logic [DEN_W-1:0]  den,
  input  logic              den_zero,
  output logic              out_v,
  input  logic              out_rdy,
  output logic [FACT_W-1:0] out_factor,
  output logic [TW-1:0]     out_tag
);

  // numerator dist << 16 and the divisor shifted up to the top quotient bit
  localparam int NW = ((DW + FRAC_W) > (DEN_W + QUO_W)) ? DW + FRAC_W : DEN_W + QUO_W;
  localparam int ST = QUO_W + 1;

  logic [ST-1:0]    v_r;
  logic [ST:0]      rdy;
  logic [ST-1:0]    sat_r;
  logic [NW-1:0]    rem_r  [ST];
  logic [QUO_W-1:0] q_r    [ST];
  logic [TW-1:0]    tag_r  [ST];
  logic [NW-1:0]    rem_nxt[ST];
  logic [QUO_W-1:0] q_nxt  [ST];
  logic [ST-1:0]    sat_nxt;
  logic [NW-1:0]    num;
  logic [NW-1:0]    dsh    [ST];
  logic [ST-1:0]    v_in;

  always_comb begin
    rdy[ST] = out_rdy;
    for (int i = ST - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign num = NW'({in_dist, {FRAC_W{1'b0}}});

  always_comb begin
    // first stage: factor saturates at one when dist * 256 >= den or den is zero
    dsh[0]     = NW'(den) << QUO_W;
    sat_nxt[0] = den_zero || (num >= dsh[0]);
    rem_nxt[0] = num;
    q_nxt[0]   = '0;
    for (int i = 1; i < ST; i++) begin
      dsh[i]     = NW'(den) << (QUO_W - i);
      sat_nxt[i] = sat_r[i-1];
      q_nxt[i]   = q_r[i-1];
      if (rem_r[i-1] >= dsh[i]) begin
        rem_nxt[i]           = rem_r[i-1] - dsh[i];
        q_nxt[i][QUO_W-i]    = 1'b1;
      end else begin
        rem_nxt[i]           = rem_r[i-1];
      end
    end
  end

  assign v_in = {v_r[ST-2:0], in_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < ST; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ST; i++) begin
      if (rdy[i]) begin
        sat_r[i] <= sat_nxt[i];
        rem_r[i] <= rem_nxt[i];
        q_r[i]   <= q_nxt[i];
        tag_r[i] <= (i == 0) ? in_tag : tag_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign in_rdy     = rdy[0];
  assign out_v      = v_r[ST-1];
  assign out_factor = sat_r[ST-1] ? FACTOR_ONE : FACT_W'(q_r[ST-1]);
  assign out_tag    = tag_r[ST-1];

endmodule

@@ sv/radial_vignette_darken.sv @@
// Radial vignette: each RGBA pixel with its column and row is darkened by a gain that
// falls with its distance from a programmable centre, measured against the distance
// from that centre to pixel (0,0) scaled by falloff_size; strength sets how dark the
// rim gets, alpha passes through. The block takes one pixel per clock and keeps doing
// so while results wait at the output until its stages fill. The pipeline has 4 front
// stages, one stage per bit of the distance square root (18 at COORD_BITS=12), 9
// divider stages and 4 gain stages. Every configuration write starts a recomputation
// of the reference distance and the divisor in a separate iterative root unit, during
// which in_tready stays low; with the centre at the origin the whole frame gets the
// full strength.
module radial_vignette_darken import rvd_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // in_tdata: pixel_col, pixel_row, in_red, in_green, in_blue, in_alpha
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((2*COORD_BITS+4*CHANNEL_BITS+7)/8)*8-1:0] in_tdata,
  // out_tdata: out_red, out_green, out_blue, out_alpha
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]          out_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [IDX_W-1:0]                             cfg_index,
  input  logic [CFG_W-1:0]                             cfg_data
);

  localparam int C      = COORD_BITS;
  localparam int CH     = CHANNEL_BITS;
  localparam int AW     = (((C + 4) > CEN_W - 1) ? C + 4 : CEN_W - 1) + 1;
  localparam int DW     = AW + 1;
  localparam int RW     = 2 * DW;
  localparam int TW     = 4 * CH;
  localparam int OUT_W  = ((4 * CH + 7) / 8) * 8;
  localparam int MW     = CH + GAIN_W;
  localparam int PW     = FACT_W + AMT_W;
  localparam int FS     = 4;
  localparam int BS     = 4;

  rvd_cfg_t cset;
  logic     den_busy;

  rvd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cset      (cset),
    .busy      (den_busy)
  );

  // front: offsets, magnitudes, squares, sum
  logic [C-1:0]         col, row;
  logic [TW-1:0]        in_tag;
  logic                 in_ok;
  logic [FS-1:0]        vf_r;
  logic [FS:0]          rdy_f;
  logic [FS-1:0]        vf_in;
  logic [TW-1:0]        tf_r [FS];
  logic signed [AW:0]   dx_r, dy_r;
  logic signed [AW:0]   dx_nxt, dy_nxt;
  logic [AW-1:0]        adx_r, ady_r;
  logic [2*AW-1:0]      sqx_r, sqy_r;
  logic [RW-1:0]        rad_r;

  assign col    = in_tdata[C-1:0];
  assign row    = in_tdata[2*C-1:C];
  assign in_tag = in_tdata[2*C +: TW];
  assign in_ok  = in_tvalid && !den_busy;

  assign dx_nxt = $signed((AW+1)'({col, 4'b0000})) - (AW+1)'(cset.cx);
  assign dy_nxt = $signed((AW+1)'({row, 4'b0000})) - (AW+1)'(cset.cy);

  logic sq_in_rdy;

  always_comb begin
    rdy_f[FS] = sq_in_rdy;
    for (int i = FS - 1; i >= 0; i--) begin
      rdy_f[i] = !vf_r[i] || rdy_f[i+1];
    end
  end

  assign in_tready = rdy_f[0] && !den_busy;
  assign vf_in     = {vf_r[FS-2:0], in_ok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else begin
      for (int i = 0; i < FS; i++) begin
        if (rdy_f[i]) begin
          vf_r[i] <= vf_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f[0]) begin
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      tf_r[0]  <= in_tag;
    end
    if (rdy_f[1]) begin
      adx_r    <= dx_r[AW] ? AW'(-dx_r) : AW'(dx_r);
      ady_r    <= dy_r[AW] ? AW'(-dy_r) : AW'(dy_r);
      tf_r[1]  <= tf_r[0];
    end
    if (rdy_f[2]) begin
      sqx_r    <= adx_r * adx_r;
      sqy_r    <= ady_r * ady_r;
      tf_r[2]  <= tf_r[1];
    end
    if (rdy_f[3]) begin
      rad_r    <= RW'(sqx_r) + RW'(sqy_r);
      tf_r[3]  <= tf_r[2];
    end
  end

  // distance root
  logic          sq_out_v, dv_in_rdy;
  logic [DW-1:0] dist_root;
  logic [TW-1:0] sq_tag;

  rvd_sqrt_pipe #(
    .DW (DW),
    .TW (TW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (vf_r[FS-1]),
    .in_rdy   (sq_in_rdy),
    .in_rad   (rad_r),
    .in_tag   (tf_r[FS-1]),
    .out_v    (sq_out_v),
    .out_rdy  (dv_in_rdy),
    .out_root (dist_root),
    .out_tag  (sq_tag)
  );

  // factor = min(256, (dist << 16) / den)
  logic              dv_out_v;
  logic [FACT_W-1:0] factor;
  logic [TW-1:0]     dv_tag;
  logic [BS:0]       rdy_b;

  rvd_div_pipe #(
    .DW (DW),
    .TW (TW)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_v       (sq_out_v),
    .in_rdy     (dv_in_rdy),
    .in_dist    (dist_root),
    .in_tag     (sq_tag),
    .den        (cset.den),
    .den_zero   (cset.den_zero),
    .out_v      (dv_out_v),
    .out_rdy    (rdy_b[0]),
    .out_factor (factor),
    .out_tag    (dv_tag)
  );

  // back: gain and channel scaling, last stage is the output register
  logic [BS-1:0]     vb_r;
  logic [BS-1:0]     vb_in;
  logic [TW-1:0]     tb_r [BS-1];
  logic [PW-1:0]     prod_r;
  logic [GAIN_W-1:0] gain_r;
  logic [MW-1:0]     m_r  [3];
  logic [MW-1:0]     msum [3];
  logic [TW-1:0]     outd_r;

  always_comb begin
    rdy_b[BS] = out_tready;
    for (int i = BS - 1; i >= 0; i--) begin
      rdy_b[i] = !vb_r[i] || rdy_b[i+1];
    end
    for (int k = 0; k < 3; k++) begin
      msum[k] = m_r[k] + MW'(ROUND_HALF);
    end
  end

  assign vb_in = {vb_r[BS-2:0], dv_out_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else begin
      for (int i = 0; i < BS; i++) begin
        if (rdy_b[i]) begin
          vb_r[i] <= vb_in[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b[0]) begin
      prod_r  <= factor * cset.amount;
      tb_r[0] <= dv_tag;
    end
    if (rdy_b[1]) begin
      gain_r  <= GAIN_ONE - prod_r[GAIN_W-1:0];
      tb_r[1] <= tb_r[0];
    end
    if (rdy_b[2]) begin
      for (int k = 0; k < 3; k++) begin
        m_r[k] <= tb_r[1][k*CH +: CH] * gain_r;
      end
      tb_r[2] <= tb_r[1];
    end
    if (rdy_b[3]) begin
      // round half up, drop the 16 gain fraction bits
      for (int k = 0; k < 3; k++) begin
        outd_r[k*CH +: CH] <= msum[k][FRAC_W +: CH];
      end
      outd_r[3*CH +: CH] <= tb_r[2][3*CH +: CH];
    end
  end

  assign out_tvalid = vb_r[BS-1];
  assign out_tdata  = OUT_W'(outd_r);

  // no pixel slips in on the edge right after a register write
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !(in_tvalid && in_tready))
    else $error("pixel accepted right after a configuration write");

  // divisor and its zero flag agree whenever pixels may flow
  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !den_busy |-> (cset.den_zero == (cset.den == '0)))
    else $error("divisor zero flag out of step with divisor");

  // factor times amount never exceeds unity gain
  a_prod_range: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r[0] |-> (prod_r <= PW'(GAIN_ONE)))
    else $error("darkening product above unity");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvd_pkg::*;

  localparam int COORD_W  = 12;
  localparam int CHAN_W   = 8;
  localparam int IN_W     = ((2*COORD_W+4*CHAN_W+7)/8)*8;
  localparam int OUT_W    = ((4*CHAN_W+7)/8)*8;
  localparam int LIMIT    = 400000;
  localparam int HOLD_LEN = 500;
  localparam int N_RAND   = 8;
  localparam int PER_RAND = 205;

  // col in the lowest bits
  typedef struct packed {
    logic [CHAN_W-1:0]  alpha;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } px_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } px_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic signed [CEN_W-1:0] cen_x;
  logic signed [CEN_W-1:0] cen_y;
  logic [AMT_W-1:0]        strength_q;
  logic [SIZE_W-1:0]       size_q;

  px_in_t  pix_queue[$];
  px_out_t pixel_due[$];

  int cycles = 0;
  int errors = 0;
  int n_checked = 0;
  int n_writes = 0;
  int n_settings = 0;
  int n_held = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic hold_trig = 1'b0;

  string chan_name[4] = '{"red", "green", "blue", "alpha"};

  radial_vignette_darken #(
    .COORD_BITS  (COORD_W),
    .CHANNEL_BITS(CHAN_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(string what);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    int b;
    r = 0;
    for (b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic px_out_t vignette_pixel(px_in_t p);
    longint dx, dy, cx, cy;
    longint unsigned rad_len, refd, den, fac, amt, sz, gain, c, scaled;
    logic [IN_W-1:0] bits;
    px_out_t o;
    int i;
    cx = longint'(cen_x);
    cy = longint'(cen_y);
    dx = 16 * longint'(p.col) - cx;
    dy = 16 * longint'(p.row) - cy;
    rad_len = int_root(longint'(dx * dx + dy * dy));
    refd = int_root(longint'(cx * cx + cy * cy));
    amt = 64'((strength_q > AMT_MAX) ? AMT_MAX : strength_q);
    sz = 64'((size_q < SIZE_MIN) ? SIZE_MIN : size_q);
    den = refd * sz;
    // centre on the origin: no reference distance, the full strength everywhere
    if (den == 0) begin
      fac = 64'(FACTOR_ONE);
    end else begin
      fac = (rad_len << 16) / den;
      if (fac > 64'(FACTOR_ONE)) fac = 64'(FACTOR_ONE);
    end
    gain = 64'(GAIN_ONE) - fac * amt;
    bits = p;
    for (i = 0; i < 3; i++) begin
      c = 64'(bits[2*COORD_W + CHAN_W*i +: CHAN_W]);
      scaled = (c * gain + 64'(ROUND_HALF)) >> FRAC_W;
      o[CHAN_W*i +: CHAN_W] = scaled[CHAN_W-1:0];
    end
    o.alpha = p.alpha;
    return o;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pix_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pix_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_trig) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && !hold_trig && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    px_out_t want;
    px_out_t got;
    int i;
    if (!rst_n) begin
      cen_x      <= CENTER_RST;
      cen_y      <= CENTER_RST;
      strength_q <= STRENGTH_RST;
      size_q     <= SIZE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X:     cen_x <= cfg_data;
          REG_CENTER_Y:     cen_y <= cfg_data;
          REG_STRENGTH:     strength_q <= cfg_data[AMT_W-1:0];
          REG_FALLOFF_SIZE: size_q <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
        n_writes++;
      end
      if (in_tvalid && in_tready) pixel_due.push_back(vignette_pixel(in_tdata));
      if (in_tvalid && !in_tready) n_held++;
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pixel_due.size() == 0) begin
          report($sformatf("word %h arrived with no pixel pending", got));
        end else begin
          want = pixel_due.pop_front();
          n_checked++;
          for (i = 0; i < 4; i++) begin
            if (got[CHAN_W*i +: CHAN_W] !== want[CHAN_W*i +: CHAN_W])
              report($sformatf("%s got %0d want %0d", chan_name[i],
                               got[CHAN_W*i +: CHAN_W], want[CHAN_W*i +: CHAN_W]));
          end
        end
      end
    end
  end

  task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the short registers carry noise
  task automatic set_regs(input logic [CEN_W-1:0] cx, input logic [CEN_W-1:0] cy,
                          input logic [AMT_W-1:0] amt, input logic [SIZE_W-1:0] sz);
    logic [31:0] junk;
    junk = $urandom;
    program_reg(REG_CENTER_X, cx);
    program_reg(REG_CENTER_Y, cy);
    program_reg(REG_STRENGTH, {junk[CFG_W-AMT_W-1:0], amt});
    program_reg(REG_FALLOFF_SIZE, {junk[CFG_W-SIZE_W+15:16], sz});
    n_settings++;
  endtask

  task automatic add_pixel(input int col, input int row, input int r, input int g,
                           input int b, input int a);
    px_in_t p;
    p.col   = COORD_W'(col);
    p.row   = COORD_W'(row);
    p.red   = CHAN_W'(r);
    p.green = CHAN_W'(g);
    p.blue  = CHAN_W'(b);
    p.alpha = CHAN_W'(a);
    pix_queue.push_back(p);
  endtask

  // wait until no pixel is queued, offered or in flight
  task automatic drain();
    do @(posedge clk);
    while (pix_queue.size() != 0 || in_tvalid || pixel_due.size() != 0);
  endtask

  function automatic logic [CEN_W-1:0] rand_centre();
    case ($urandom_range(3))
      0: return CEN_W'($urandom);
      1: return CEN_W'(16 * $urandom_range(4095) + $urandom_range(15));
      2: return CEN_W'(-int'($urandom_range(4000)));
      default: return '0;
    endcase
  endfunction

  function automatic px_in_t rand_pixel();
    px_in_t p;
    p = IN_W'({$urandom, $urandom});
    if ($urandom_range(15) == 0) p.col = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(15) == 0) p.row = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(15) == 0) p.red = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(15) == 0) p.alpha = $urandom_range(1) ? '1 : '0;
    return p;
  endfunction

  initial begin : stimulus
    int p;
    int k;
    logic [CEN_W-1:0] cx;
    logic [CEN_W-1:0] cy;
    logic [AMT_W-1:0] amt;
    logic [SIZE_W-1:0] sz;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: centre at the origin, half strength
    add_pixel(0, 0, 0, 0, 0, 0);
    add_pixel(4095, 4095, 255, 255, 255, 255);
    add_pixel(0, 4095, 255, 0, 128, 1);
    add_pixel(4095, 0, 1, 254, 127, 0);
    add_pixel(2048, 2047, 170, 85, 255, 128);
    drain();

    // extreme centres, strength above full, size below minimum
    set_regs(17'h0FFFF, 17'h10000, 9'd511, 12'd0);
    add_pixel(0, 0, 255, 255, 255, 255);
    add_pixel(4095, 4095, 255, 255, 255, 255);
    add_pixel(4095, 0, 200, 100, 50, 7);
    add_pixel(0, 4095, 255, 1, 0, 255);
    drain();

    // centre mid image, widest falloff; the centre pixel keeps its value
    set_regs(CEN_W'(32768), CEN_W'(32768), 9'd256, 12'd4095);
    add_pixel(2048, 2048, 255, 255, 255, 9);
    add_pixel(0, 0, 255, 255, 255, 255);
    add_pixel(4095, 4095, 128, 64, 32, 16);
    add_pixel(2049, 2048, 255, 3, 1, 200);
    drain();

    // narrowest falloff saturates almost at once
    set_regs(CEN_W'(32776), CEN_W'(1600), 9'd256, 12'd3);
    add_pixel(0, 0, 255, 255, 255, 255);
    add_pixel(2048, 100, 255, 255, 255, 255);
    add_pixel(2049, 100, 99, 100, 101, 3);
    add_pixel(4095, 4095, 1, 2, 3, 4);
    drain();

    // zero strength leaves colors alone, centre just off the image
    set_regs(CEN_W'(-16), '0, 9'd0, 12'd256);
    add_pixel(0, 0, 255, 254, 1, 0);
    add_pixel(4095, 4095, 17, 34, 51, 68);
    add_pixel(1, 0, 128, 127, 129, 255);
    drain();

    for (p = 0; p < N_RAND; p++) begin
      cx  = rand_centre();
      cy  = rand_centre();
      if (p == 5) begin
        cx = '0;
        cy = '0;
      end
      amt = ($urandom_range(3) == 0) ? AMT_W'($urandom_range(511)) : AMT_W'($urandom_range(256));
      case ($urandom_range(2))
        0: sz = SIZE_W'($urandom_range(4095));
        1: sz = SIZE_W'($urandom_range(8));
        default: sz = SIZE_W'($urandom_range(1024, 64));
      endcase
      set_regs(cx, cy, amt, sz);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          send_idle_pct = 36;
          stall_pct = 36;
        end
      endcase
      for (k = 0; k < PER_RAND; k++) pix_queue.push_back(rand_pixel());
      drain();

      // output held off while pixels keep coming, so the pipeline backs up
      if (p == 1) begin
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_trig <= 1'b1;
        @(posedge clk);
        hold_trig <= 1'b0;
        for (k = 0; k < 120; k++) pix_queue.push_back(rand_pixel());
        drain();
      end
    end

    repeat (60) @(posedge clk);
    $display("%0d pixels checked across %0d register settings (%0d writes)",
             n_checked, n_settings, n_writes);
    $display("pixel input back-pressured for %0d cycles, %0d mismatches", n_held, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
